// ===== rtl/sm3_pkg.sv =====
// shared types, constants and bit functions of the sm3 hash engine
package sm3_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [0:7] regs_type;
   typedef word_type [0:15] win_type;

   localparam regs_type SM3_IV = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };
   localparam word_type T_LOW    = 32'h79CC4519;
   localparam word_type T_HIGH   = 32'h7A879D8A;
   localparam word_type PAD_WORD = 32'h80000000;
   localparam int       ROUNDS   = 64;

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   function automatic word_type perm0(input word_type x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic word_type perm1(input word_type x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// ===== rtl/sm3_round.sv =====
// one sm3 compression round and one message expansion step
module sm3_round
   import sm3_pkg::*;
(
   input  regs_type    regs,
   input  win_type     win,
   input  logic [5:0]  rnd,
   output regs_type    regs_next,
   output word_type    new_word
);

   word_type tj;
   word_type a12;
   word_type ss1;
   word_type ss2;
   word_type ff;
   word_type gg;
   word_type tt1;
   word_type tt2;
   logic     early;

   always_comb begin
      early = (rnd[5:4] == 2'd0);
      tj    = early ? T_LOW : T_HIGH;
      a12   = rotl(regs[0], 5'd12);
      ss1   = rotl(a12 + regs[4] + rotl(tj, rnd[4:0]), 5'd7);
      ss2   = ss1 ^ a12;
      if (early) begin
         ff = regs[0] ^ regs[1] ^ regs[2];
         gg = regs[4] ^ regs[5] ^ regs[6];
      end else begin
         ff = (regs[0] & regs[1]) | (regs[0] & regs[2]) | (regs[1] & regs[2]);
         gg = (regs[4] & regs[5]) | (~regs[4] & regs[6]);
      end
      tt1 = ff + regs[3] + ss2 + (win[0] ^ win[4]);
      tt2 = gg + regs[7] + ss1 + win[0];
      regs_next[0] = tt1;
      regs_next[1] = regs[0];
      regs_next[2] = rotl(regs[1], 5'd9);
      regs_next[3] = regs[2];
      regs_next[4] = perm0(tt2);
      regs_next[5] = regs[4];
      regs_next[6] = rotl(regs[5], 5'd19);
      regs_next[7] = regs[6];
      new_word = perm1(win[0] ^ win[7] ^ rotl(win[13], 5'd15))
                 ^ rotl(win[3], 5'd7) ^ win[10];
   end

endmodule

// ===== rtl/sm3_hash.sv =====
// sm3 hash engine top level: word intake, padding, round sequencer, digest output
//
// req channel carries the message as big-endian 32-bit words; req_tlast marks the
// final word, whose valid_bytes field (0 to 4, larger taken as 4) gives its valid
// leading bytes. every other word counts as four full bytes.
// each sixteenth word starts a compression, one round per cycle on the
// shared round unit; req_tready is low meanwhile.
// after the last word the padding words are pushed one per cycle while no compression runs
// (up to 18, with one or two compressions), then the digest leaves on the rsp channel as
// eight beats, index 0 first, rsp_tlast on index 7. req_tready stays low until the
// eighth beat is taken; a stalled rsp simply holds the current beat.
// the engine then returns to the initial vector and a zero length for a new message.
// reset (synchronous, active high) clears the sequencer and the length count and loads the
// initial vector into the chaining value at once; no clearing pass follows.
module sm3_hash
   import sm3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // message_word[31:0], valid_bytes[34:32], zeros
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], digest_index[34:32], zeros
   output logic        rsp_tlast
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_PAD, ST_OUT} state_type;

   state_type   state_ff, state_in;
   regs_type    chain_ff, chain_in;
   regs_type    regs_ff, regs_in;
   win_type     win_ff, win_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [3:0]  pos_ff, pos_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  idx_ff, idx_in;
   logic        pad_ff, pad_in;
   logic        pend80_ff, pend80_in;
   logic        hidone_ff, hidone_in;
   logic        fin_ff, fin_in;

   regs_type    round_regs;
   word_type    round_word;
   word_type    msg_word;
   logic [2:0]  vbytes;
   logic [2:0]  ksat;
   logic        push;
   word_type    push_word;
   logic        in_beat;

   sm3_round u_round (
      .regs      (regs_ff),
      .win       (win_ff),
      .rnd       (rnd_ff),
      .regs_next (round_regs),
      .new_word  (round_word)
   );

   assign msg_word   = req_tdata[31:0];
   assign vbytes     = req_tdata[34:32];
   assign ksat       = (vbytes > 3'd4) ? 3'd4 : vbytes;
   assign req_tready = (state_ff == ST_IDLE);
   assign in_beat    = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, idx_ff, chain_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'd7);

   always_comb begin
      state_in  = state_ff;
      chain_in  = chain_ff;
      regs_in   = regs_ff;
      win_in    = win_ff;
      bitlen_in = bitlen_ff;
      pos_in    = pos_ff;
      rnd_in    = rnd_ff;
      idx_in    = idx_ff;
      pad_in    = pad_ff;
      pend80_in = pend80_ff;
      hidone_in = hidone_ff;
      fin_in    = fin_ff;
      push      = 1'b0;
      push_word = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_beat) begin
               push = 1'b1;
               if (!req_tlast) begin
                  push_word = msg_word;
                  bitlen_in = bitlen_ff + 64'd32;
               end else begin
                  bitlen_in = bitlen_ff + {58'd0, ksat, 3'd0};
                  pad_in    = 1'b1;
                  state_in  = ST_PAD;
                  case (ksat)
                     3'd0:    push_word = PAD_WORD;
                     3'd1:    push_word = {msg_word[31:24], 24'h800000};
                     3'd2:    push_word = {msg_word[31:16], 16'h8000};
                     3'd3:    push_word = {msg_word[31:8], 8'h80};
                     default: begin
                        push_word = msg_word;
                        pend80_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (pend80_ff) begin
               push_word = PAD_WORD;
               pend80_in = 1'b0;
            end else if (hidone_ff) begin
               push_word = bitlen_ff[31:0];
               fin_in    = 1'b1;
            end else if (pos_ff == 4'd14) begin
               push_word = bitlen_ff[63:32];
               hidone_in = 1'b1;
            end
         end
         ST_ROUND: begin
            regs_in = round_regs;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = round_word;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == 6'(ROUNDS - 1)) begin
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = chain_ff[i] ^ round_regs[i];
               end
               if (!pad_ff) begin
                  state_in = ST_IDLE;
               end else if (fin_ff) begin
                  state_in  = ST_OUT;
                  pad_in    = 1'b0;
                  hidone_in = 1'b0;
                  fin_in    = 1'b0;
                  idx_in    = 3'd0;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in  = ST_IDLE;
                  chain_in  = SM3_IV;
                  bitlen_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         win_in[pos_ff] = push_word;
         pos_in         = pos_ff + 4'd1;
         if (pos_ff == 4'd15) begin
            regs_in  = chain_ff;
            rnd_in   = '0;
            state_in = ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         chain_ff  <= SM3_IV;
         regs_ff   <= '0;
         bitlen_ff <= '0;
         pos_ff    <= '0;
         rnd_ff    <= '0;
         idx_ff    <= '0;
         pad_ff    <= 1'b0;
         pend80_ff <= 1'b0;
         hidone_ff <= 1'b0;
         fin_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         chain_ff  <= chain_in;
         regs_ff   <= regs_in;
         bitlen_ff <= bitlen_in;
         pos_ff    <= pos_in;
         rnd_ff    <= rnd_in;
         idx_ff    <= idx_in;
         pad_ff    <= pad_in;
         pend80_ff <= pend80_in;
         hidone_ff <= hidone_in;
         fin_ff    <= fin_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("intake and digest output active together");

   a_ready_after_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && (chain_ff == SM3_IV))
      else $error("engine not restarted after final digest beat");

   a_block_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pos_ff == 4'd0) && !pad_ff)
      else $error("digest shown with a partly filled block");

   a_rounds_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && (rnd_ff != 6'(ROUNDS - 1)) |=> (state_ff == ST_ROUND))
      else $error("compression left before the last round");
`endif

endmodule

// ===== tb/sv/tb_sm3_hash.sv =====
// self-checking testbench for the sm3 hash engine: random and directed messages vs digest model
module tb_sm3_hash;
   import sm3_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEM_BUDGET = 420;

   typedef struct packed {
      word_type   word;
      logic [2:0] pos;
      logic       last;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // message_word[31:0], valid_bytes[34:32], zeros
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // digest_word[31:0], digest_index[34:32], zeros
   logic        rsp_tlast;

   // digest model state
   word_type        chain [8];
   word_type        blk_words [16];
   int unsigned     fill;
   logic [63:0]     bit_count;
   digest_beat_type pending_digest [$];

   int unsigned  words_sent = 0;
   int unsigned  errors = 0;
   int unsigned  cycle_count = 0;
   int unsigned  hold_req = 0;
   bit           quiet = 1'b0;

   sm3_hash i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic word_type rot_left(input word_type x, input int unsigned n);
      int unsigned s;
      s = n % 32;
      if (s == 0) return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic word_type sm3_p0(input word_type x);
      return x ^ rot_left(x, 9) ^ rot_left(x, 17);
   endfunction

   function automatic word_type sm3_p1(input word_type x);
      return x ^ rot_left(x, 15) ^ rot_left(x, 23);
   endfunction

   function automatic void restart_digest();
      for (int i = 0; i < 8; i++) chain[i] = SM3_IV[i];
      bit_count = '0;
      fill = 0;
   endfunction

   function automatic void compress_block();
      word_type r [8];
      word_type w [16];
      word_type wj, wp, tj, a12, ss1, ss2, ff, gg, tt1, tt2, nw;
      for (int i = 0; i < 16; i++) w[i] = blk_words[i];
      for (int i = 0; i < 8; i++) r[i] = chain[i];
      for (int j = 0; j < 64; j++) begin
         wj  = w[0];
         wp  = wj ^ w[4];
         tj  = (j < 16) ? T_LOW : T_HIGH;
         a12 = rot_left(r[0], 12);
         ss1 = rot_left(a12 + r[4] + rot_left(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = r[0] ^ r[1] ^ r[2];
            gg = r[4] ^ r[5] ^ r[6];
         end else begin
            ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
            gg = (r[4] & r[5]) | (~r[4] & r[6]);
         end
         tt1 = ff + r[3] + ss2 + wp;
         tt2 = gg + r[7] + ss1 + wj;
         r[3] = r[2]; r[2] = rot_left(r[1], 9);  r[1] = r[0]; r[0] = tt1;
         r[7] = r[6]; r[6] = rot_left(r[5], 19); r[5] = r[4]; r[4] = sm3_p0(tt2);
         nw = sm3_p1(w[0] ^ w[7] ^ rot_left(w[13], 15)) ^ rot_left(w[3], 7) ^ w[10];
         for (int i = 0; i < 15; i++) w[i] = w[i + 1];
         w[15] = nw;
      end
      for (int i = 0; i < 8; i++) chain[i] ^= r[i];
   endfunction

   function automatic void push_block_word(input word_type w);
      blk_words[fill] = w;
      fill = (fill + 1) % 16;
      if (fill == 0) compress_block();
   endfunction

   function automatic void absorb_word(input word_type w, input logic [2:0] vb, input logic last);
      int unsigned     k;
      word_type        mask;
      digest_beat_type beat;
      if (!last) begin
         bit_count += 64'd32;
         push_block_word(w);
         return;
      end
      k = (vb > 3'd4) ? 4 : vb;
      bit_count += 64'(8 * k);
      if (k == 4) begin
         push_block_word(w);
         push_block_word(PAD_WORD);
      end else begin
         mask = (k == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * k));
         push_block_word((w & mask) | (32'h80 << (24 - 8 * k)));
      end
      while (fill != 14) push_block_word('0);
      push_block_word(bit_count[63:32]);
      push_block_word(bit_count[31:0]);
      for (int i = 0; i < 8; i++) begin
         beat.word = chain[i];
         beat.pos  = 3'(i);
         beat.last = (i == 7);
         pending_digest = {pending_digest, beat};
      end
      restart_digest();
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input word_type w, input logic [2:0] vb, input logic last);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 40'({$urandom, $urandom});
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, vb, w};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      absorb_word(w, vb, last);
      words_sent++;
   endtask

   // body words carry a random (ignored) byte count
   task automatic send_message(input int unsigned body_len, input logic [2:0] last_vb);
      for (int i = 0; i < body_len; i++) send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
      send_word(rand_word(), last_vb, 1'b1);
   endtask

   task automatic test_short_messages();
      send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
      send_word(32'h6162_63FF, 3'd3, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
      send_word(32'h0000_0000, 3'd2, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
      send_word($urandom, 3'd5, 1'b1);
      send_word($urandom, 3'd6, 1'b1);
      send_word(32'h0000_0000, 3'd7, 1'b1);
   endtask

   // thirteen body words plus a full last word push padding into a second block
   task automatic test_extra_block();
      for (int i = 0; i < 13; i++)
         send_word((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, 3'(i % 8), 1'b0);
      send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
   endtask

   task automatic test_back_pressure();
      quiet    = 1'b1;
      hold_req = 600;
      for (int m = 0; m < 3; m++) send_message($urandom_range(6, 14), 3'($urandom_range(0, 4)));
      quiet = 1'b0;
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      for (int m = 0; m < 4; m++) send_message($urandom_range(0, 18), 3'($urandom_range(0, 7)));
      quiet = 1'b0;
   endtask

   task automatic test_random_messages();
      int unsigned body_len;
      logic [2:0]  last_vb;
      while (words_sent < ITEM_BUDGET) begin
         if ($urandom_range(0, 7) == 0) body_len = $urandom_range(20, 48);
         else body_len = $urandom_range(0, 20);
         if ($urandom_range(0, 3) == 0) last_vb = 3'($urandom_range(5, 7));
         else last_vb = 3'($urandom_range(0, 4));
         send_message(body_len, last_vb);
      end
   endtask

   // receiver side
   initial begin
      int unsigned hold_left;
      int unsigned stall_left;
      hold_left  = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      digest_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digest.size() == 0) begin
            $display("%0t: unexpected digest beat %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            want = pending_digest.pop_front();
            if (rsp_tdata[31:0] !== want.word) begin
               $display("%0t: digest word expected %h got %h",
                        $realtime, want.word, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[34:32] !== want.pos) begin
               $display("%0t: digest index expected %0d got %0d",
                        $realtime, want.pos, rsp_tdata[34:32]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: digest last expected %b got %b",
                        $realtime, want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout", $realtime);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      restart_digest();
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_short_messages();
      test_extra_block();
      test_back_pressure();
      test_back_to_back();
      test_random_messages();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (pending_digest.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sm3_pkg.sv
rtl/sm3_round.sv
rtl/sm3_hash.sv
tb/sv/tb_sm3_hash.sv
